FILE: rtl/core/gsa_pkg.sv
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Shared widths, request and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int KIND_W = 2;
    localparam int IDX_W  = 6;
    localparam int GEN_W  = 8;
    localparam int ST_W   = 2;

    // Free flags are searched in groups of this many bits.
    localparam int GROUP_W    = 32;
    localparam int GROUP_BITS = 5;

    localparam logic [KIND_W-1:0] K_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] K_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] K_LOOKUP = 2'd2;
    localparam logic [KIND_W-1:0] K_RESET  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_STALE   = 2'd2;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic clear;
        logic find;
        logic pick;
        logic gen;
        logic check;
        logic out_load;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              in_valid;
        logic [KIND_W-1:0] in_kind;
        logic              clear_done;
        logic              any_free;
        logic              out_space;
    } t_sts;

endpackage

FILE: rtl/core/gsa_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocator request word.
// ----------------------------------------------------------------------------
interface gsa_req_if;
    logic                          valid;
    logic                          ready;
    logic [gsa_pkg::KIND_W-1:0]    kind;
    logic                          handle_valid;
    logic [gsa_pkg::IDX_W-1:0]     slot_index;
    logic [gsa_pkg::GEN_W-1:0]     handle_generation;

    modport source (
        output valid, kind, handle_valid, slot_index, handle_generation,
        input  ready
    );
    modport sink (
        input  valid, kind, handle_valid, slot_index, handle_generation,
        output ready
    );
endinterface

FILE: rtl/core/gsa_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one allocator response word.
// ----------------------------------------------------------------------------
interface gsa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [gsa_pkg::ST_W-1:0]    status;
    logic [gsa_pkg::IDX_W-1:0]   result_index;
    logic [gsa_pkg::GEN_W-1:0]   result_generation;

    modport source (
        output valid, status, result_index, result_generation,
        input  ready
    );
    modport sink (
        input  valid, status, result_index, result_generation,
        output ready
    );
endinterface

FILE: rtl/core/gsa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the clearing pass and the steps of each request.
// ----------------------------------------------------------------------------
module gsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gsa_pkg::t_sts i_sts,
    output gsa_pkg::t_ctl o_ctl
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_GEN   = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    case (i_sts.in_kind)
                        gsa_pkg::K_ALLOC: n_state = S_FIND;
                        gsa_pkg::K_RESET: n_state = S_RESP;
                        default:          n_state = S_CHECK;
                    endcase
                end
            end
            S_FIND: begin
                o_ctl.find = 1'b1;
                n_state    = S_PICK;
            end
            S_PICK: begin
                o_ctl.pick = 1'b1;
                n_state    = i_sts.any_free ? S_GEN : S_RESP;
            end
            S_GEN: begin
                o_ctl.gen = 1'b1;
                n_state   = S_RESP;
            end
            S_CHECK: begin
                o_ctl.check = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_space) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/gsa_dp.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Free flags, generation memory with epoch offset, search and result registers.
// ----------------------------------------------------------------------------
module gsa_dp #(
    parameter int SLOTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gsa_pkg::t_ctl i_ctl,
    output gsa_pkg::t_sts o_sts,
    gsa_req_if.sink       i_req,
    gsa_rsp_if.source     o_rsp
);

    localparam int IW  = $clog2(SLOTS);
    localparam int AW  = (IW > gsa_pkg::IDX_W) ? IW : gsa_pkg::IDX_W;
    localparam int NG  = (SLOTS + gsa_pkg::GROUP_W - 1) / gsa_pkg::GROUP_W;
    localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int FW  = GW + gsa_pkg::GROUP_BITS;
    localparam int PW  = (FW > IW) ? FW : IW;
    localparam int NB  = NG * gsa_pkg::GROUP_W;
    localparam logic [NB-1:0] FREE_INIT = {NB{1'b1}} >> (NB - SLOTS);

    // Request word.
    logic [gsa_pkg::KIND_W-1:0] r_kind;
    logic                       r_hv;
    logic [gsa_pkg::IDX_W-1:0]  r_idx;
    logic [gsa_pkg::GEN_W-1:0]  r_hgen;
    logic [IW-1:0]              r_addr;

    // Slot state.
    logic [NB-1:0]              r_free;
    logic [NB-1:0]              n_free;
    logic [gsa_pkg::GEN_W-1:0]  r_epoch;
    logic [gsa_pkg::GEN_W-1:0]  mem [SLOTS];
    logic [gsa_pkg::GEN_W-1:0]  r_rd;
    logic [IW-1:0]              r_clr;

    // Search.
    logic [NG-1:0]              grp_any;
    logic [GW-1:0]              find_grp;
    logic [GW-1:0]              r_grp;
    logic                       r_any;
    logic [gsa_pkg::GROUP_W-1:0]    grp_bits;
    logic [gsa_pkg::GROUP_BITS-1:0] pick_bit;
    logic [FW-1:0]              pick_full;
    logic [PW-1:0]              pick_ext;

    // Pending and output result.
    logic [gsa_pkg::ST_W-1:0]   r_st;
    logic [gsa_pkg::IDX_W-1:0]  r_ri;
    logic [gsa_pkg::GEN_W-1:0]  r_rg;
    logic                       r_ov;
    logic [gsa_pkg::ST_W-1:0]   r_o_st;
    logic [gsa_pkg::IDX_W-1:0]  r_o_ri;
    logic [gsa_pkg::GEN_W-1:0]  r_o_rg;

    logic                       accept;
    logic                       in_reset;
    logic [AW-1:0]              in_ext;
    logic                       in_range;
    logic [gsa_pkg::GEN_W-1:0]  eff_gen;
    logic                       hit;
    logic                       free_hit;
    logic                       mem_we;
    logic [IW-1:0]              mem_wa;
    logic [gsa_pkg::GEN_W-1:0]  mem_wd;
    logic                       mem_re;
    logic [IW-1:0]              mem_ra;

    assign accept   = i_ctl.in_ready && i_req.valid;
    assign in_reset = accept && (i_req.kind == gsa_pkg::K_RESET);
    assign in_ext   = AW'(i_req.slot_index);

    assign i_req.ready = i_ctl.in_ready;

    assign o_sts.in_valid   = i_req.valid;
    assign o_sts.in_kind    = i_req.kind;
    assign o_sts.clear_done = (r_clr == IW'(SLOTS - 1));
    assign o_sts.any_free   = r_any;
    assign o_sts.out_space  = !r_ov || o_rsp.ready;

    // Group summaries and lowest non-empty group.
    always_comb begin
        find_grp = '0;
        for (int g = 0; g < NG; g++) begin
            grp_any[g] = |r_free[g*gsa_pkg::GROUP_W +: gsa_pkg::GROUP_W];
        end
        for (int g = NG - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                find_grp = GW'(g);
            end
        end
    end

    // Lowest free bit inside the chosen group.
    always_comb begin
        grp_bits = '0;
        pick_bit = '0;
        for (int g = 0; g < NG; g++) begin
            if (GW'(g) == r_grp) begin
                grp_bits = r_free[g*gsa_pkg::GROUP_W +: gsa_pkg::GROUP_W];
            end
        end
        for (int b = gsa_pkg::GROUP_W - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                pick_bit = gsa_pkg::GROUP_BITS'(b);
            end
        end
    end

    assign pick_full = {r_grp, pick_bit};
    assign pick_ext  = PW'(pick_full);

    // Effective generation is the stored value plus the reset epoch.
    assign eff_gen  = r_rd + r_epoch;
    assign in_range = (AW + 1)'(r_idx) < (AW + 1)'(SLOTS);
    assign hit      = r_hv && in_range && (eff_gen == r_hgen);
    assign free_hit = i_ctl.check && hit && (r_kind == gsa_pkg::K_FREE);

    always_comb begin
        n_free = r_free;
        if (in_reset) begin
            n_free = FREE_INIT;
        end else if (i_ctl.pick && r_any) begin
            for (int i = 0; i < NB; i++) begin
                if (FW'(i) == pick_full) begin
                    n_free[i] = 1'b0;
                end
            end
        end else if (free_hit) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (IW'(i) == r_addr) begin
                    n_free[i] = 1'b1;
                end
            end
        end
    end

    // Generation memory ports.
    always_comb begin
        mem_we = i_ctl.clear || free_hit;
        mem_wa = i_ctl.clear ? r_clr : r_addr;
        mem_wd = i_ctl.clear ? '0 : r_rd + 8'd1;
        mem_re = accept || i_ctl.pick;
        mem_ra = i_ctl.pick ? pick_ext[IW-1:0] : in_ext[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= FREE_INIT;
            r_epoch <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_free <= n_free;
            if (in_reset) begin
                r_epoch <= r_epoch + 8'd1;
            end
            if (i_ctl.clear) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_ctl.out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_req.kind;
            r_hv   <= i_req.handle_valid;
            r_idx  <= i_req.slot_index;
            r_hgen <= i_req.handle_generation;
            r_addr <= in_ext[IW-1:0];
        end
        if (in_reset) begin
            r_st <= gsa_pkg::ST_OK;
            r_ri <= '0;
            r_rg <= '0;
        end
        if (i_ctl.find) begin
            r_grp <= find_grp;
            r_any <= |grp_any;
        end
        if (i_ctl.pick) begin
            if (r_any) begin
                r_st <= gsa_pkg::ST_OK;
                r_ri <= pick_full[gsa_pkg::IDX_W-1:0];
            end else begin
                r_st <= gsa_pkg::ST_FULL;
                r_ri <= '0;
                r_rg <= '0;
            end
        end
        if (i_ctl.gen) begin
            r_rg <= eff_gen;
        end
        if (i_ctl.check) begin
            r_ri <= r_idx;
            if (!r_hv || !in_range) begin
                r_st <= gsa_pkg::ST_INVALID;
                r_rg <= '0;
            end else if (!hit) begin
                r_st <= gsa_pkg::ST_STALE;
                r_rg <= eff_gen;
            end else begin
                r_st <= gsa_pkg::ST_OK;
                r_rg <= (r_kind == gsa_pkg::K_FREE) ? eff_gen + 8'd1 : eff_gen;
            end
        end
        if (i_ctl.out_load) begin
            r_o_st <= r_st;
            r_o_ri <= r_ri;
            r_o_rg <= r_rg;
        end
    end

    assign o_rsp.valid             = r_ov;
    assign o_rsp.status            = r_o_st;
    assign o_rsp.result_index      = r_o_ri;
    assign o_rsp.result_generation = r_o_rg;

    // A bulk reset advances every effective generation by exactly one.
    a_epoch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_reset |=> (r_epoch == $past(r_epoch) + 8'd1))
        else $error("epoch did not advance on bulk reset");

    // The controller loads a result only when the output register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> (!r_ov || o_rsp.ready))
        else $error("pending response word overwritten");

    // A full pool reports a zero handle.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_o_st == gsa_pkg::ST_FULL)) |-> (r_o_ri == '0 && r_o_rg == '0))
        else $error("pool full response carries a handle");

endmodule

FILE: rtl/core/generational_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Generational slot allocator core
// Pool of SLOTS slots, each with a free flag and an 8-bit wrapping generation.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_req, one word per handshake, and each request
// produces exactly one response word on o_rsp. A request word holds the kind
// (allocate, free, look up, reset all) and a handle (valid bit, slot index,
// generation); a response word holds a status, a slot index and a generation.
// Reset all goes straight to the response; free and look up first pass a
// handle check, and allocate a group search, a slot pick and a generation
// step (skipped when the pool is full). The block takes one request at a
// time: the next word is accepted only after the previous response is
// loaded into the output register. Allocate picks the lowest 32-slot group
// with a free slot, then the slot inside it, then takes its generation from
// the memory read; free and look up read the generation memory as they are
// accepted. After reset a clearing pass writes zero to every generation
// entry, one per cycle; i_req.ready stays low until it completes.
// The response sits in an output register; while the receiver stalls, the
// block may finish the next request and holds it until the register drains.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core #(
    parameter int SLOTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gsa_req_if.sink   i_req,
    gsa_rsp_if.source o_rsp
);

    // Control and status between the sequencer and the datapath.
    gsa_pkg::t_ctl ctl;
    gsa_pkg::t_sts sts;

    // The controller walks each request through its steps: search, memory
    // read, compare, then hand-off to the output register.
    gsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // The datapath keeps free flags in flip-flops and generations in a memory.
    // A bulk reset sets every free flag and bumps a common epoch added to every
    // stored generation instead of rewriting the memory, whatever the pool size.
    gsa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: dv/gsa_response_checker.sv
// ----------------------------------------------------------------------------
// Slot allocator response checker
// Tracks every accepted request word, predicts its response from a private
// copy of the pool and compares each accepted response word field by field.
// ----------------------------------------------------------------------------
module gsa_response_checker #(
    parameter int SLOTS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    gsa_req_if                                    i_req,
    gsa_rsp_if                                    i_rsp,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked,
    output int                                    o_full_seen,
    output logic [SLOTS-1:0]                      o_free_view,
    output logic [SLOTS-1:0][gsa_pkg::GEN_W-1:0]  o_gen_view
);

    typedef struct packed {
        logic [gsa_pkg::ST_W-1:0]  status;
        logic [gsa_pkg::IDX_W-1:0] result_index;
        logic [gsa_pkg::GEN_W-1:0] result_generation;
    } t_rsp_word;

    // Private copy of the pool: free flags and generations.
    logic [SLOTS-1:0]                     slot_free_q;
    logic [SLOTS-1:0][gsa_pkg::GEN_W-1:0] slot_gen_q;
    t_rsp_word                            awaited_rsp[$];

    assign o_free_view = slot_free_q;
    assign o_gen_view  = slot_gen_q;

    // Applies one request to the pool copy and returns the response it causes.
    task automatic predict_response(
        input  logic [gsa_pkg::KIND_W-1:0] kind,
        input  logic                       handle_valid,
        input  logic [gsa_pkg::IDX_W-1:0]  slot_index,
        input  logic [gsa_pkg::GEN_W-1:0]  handle_gen,
        output t_rsp_word                  word
    );
        bit found;
        found = 1'b0;
        word  = '{gsa_pkg::ST_OK, '0, '0};
        case (kind)
            gsa_pkg::K_ALLOC: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!found && slot_free_q[s]) begin
                        found                  = 1'b1;
                        slot_free_q[s]         = 1'b0;
                        word.result_index      = gsa_pkg::IDX_W'(s);
                        word.result_generation = slot_gen_q[s];
                    end
                end
                if (!found) begin
                    word.status = gsa_pkg::ST_FULL;
                end
            end
            gsa_pkg::K_RESET: begin
                for (int s = 0; s < SLOTS; s++) begin
                    slot_free_q[s] = 1'b1;
                    slot_gen_q[s]  = slot_gen_q[s] + 1'b1;
                end
            end
            default: begin
                word.result_index = slot_index;
                if (!handle_valid || int'(slot_index) >= SLOTS) begin
                    word.status = gsa_pkg::ST_INVALID;
                end else if (slot_gen_q[slot_index] != handle_gen) begin
                    word.status            = gsa_pkg::ST_STALE;
                    word.result_generation = slot_gen_q[slot_index];
                end else begin
                    if (kind == gsa_pkg::K_FREE) begin
                        slot_free_q[slot_index] = 1'b1;
                        slot_gen_q[slot_index]  = slot_gen_q[slot_index] + 1'b1;
                    end
                    word.result_generation = slot_gen_q[slot_index];
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("response %0d: %s expected %0d, got %0d", o_checked, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp_word seen;
        t_rsp_word want;
        if (!i_rst_n) begin
            slot_free_q = '1;
            slot_gen_q  = '0;
            awaited_rsp.delete();
            o_pending   = 0;
        end else begin
            // A response always belongs to an older request, so it is
            // retired before this edge's request is queued.
            if (i_rsp.valid && i_rsp.ready) begin
                seen.status            = i_rsp.status;
                seen.result_index      = i_rsp.result_index;
                seen.result_generation = i_rsp.result_generation;
                if (awaited_rsp.size() == 0) begin
                    $error("response word arrived with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = awaited_rsp.pop_front();
                    compare_field("status", want.status, seen.status);
                    compare_field("result_index", want.result_index, seen.result_index);
                    compare_field("result_generation", want.result_generation,
                                  seen.result_generation);
                    o_checked++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_response(i_req.kind, i_req.handle_valid, i_req.slot_index,
                                 i_req.handle_generation, want);
                if (want.status == gsa_pkg::ST_FULL) begin
                    o_full_seen++;
                end
                awaited_rsp.push_back(want);
            end
            o_pending = awaited_rsp.size();
        end
    end

endmodule

FILE: dv/tb_generational_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Generational slot allocator core testbench
// Drives directed and random request words against the core, with random
// stalls on both channels, and takes the verdict from the response checker.
// ----------------------------------------------------------------------------
module tb_generational_slot_allocator_core;

    localparam int SLOTS          = 64;
    localparam int RANDOM_WORDS   = 1900;
    // Cycles without any handshake before the run is declared hung. This is far
    // above any legitimate gap: the clearing pass after reset, or a single
    // request plus the receiver's stalls.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last response, covering the longest latency.
    localparam int DRAIN_CYCLES   = 8;

    logic i_clk;
    logic i_rst_n;

    gsa_req_if req_if ();
    gsa_rsp_if rsp_if ();

    generational_slot_allocator_core #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    int                                   fail_count;
    int                                   pending_count;
    int                                   checked_count;
    int                                   full_count;
    logic [SLOTS-1:0]                     free_view;
    logic [SLOTS-1:0][gsa_pkg::GEN_W-1:0] gen_view;

    gsa_response_checker #(
        .SLOTS(SLOTS)
    ) u_response_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_fail_count(fail_count),
        .o_pending   (pending_count),
        .o_checked   (checked_count),
        .o_full_seen (full_count),
        .o_free_view (free_view),
        .o_gen_view  (gen_view)
    );

    // Stimulus bookkeeping. The predicted pool state from the checker is used
    // only to build well-formed handles; it never decides pass or fail here.
    int words_sent;
    int kind_count [4];
    bit idle_en;
    int stall_left;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls in bursts of random length while idling is enabled.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // The watchdog restarts on any handshake on either channel.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d cycles without a handshake", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Sends one request word. It is entered and left at a falling edge; an
    // optional idle burst comes first, then the word is held until the edge
    // at which the block accepts it. valid is written once per time step.
    task automatic send_word(
        input logic [gsa_pkg::KIND_W-1:0] kind,
        input logic                       handle_valid,
        input logic [gsa_pkg::IDX_W-1:0]  slot_index,
        input logic [gsa_pkg::GEN_W-1:0]  handle_gen
    );
        int gap;
        gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid             <= 1'b1;
        req_if.kind              <= kind;
        req_if.handle_valid      <= handle_valid;
        req_if.slot_index        <= slot_index;
        req_if.handle_generation <= handle_gen;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        words_sent++;
        kind_count[kind]++;
    endtask

    // An allocate word; the handle fields are ignored, so they carry noise.
    task automatic send_alloc();
        send_word(gsa_pkg::K_ALLOC, 1'($urandom_range(0, 1)),
                  gsa_pkg::IDX_W'($urandom_range(0, 63)),
                  gsa_pkg::GEN_W'($urandom_range(0, 255)));
    endtask

    // Picks a random slot that is currently allocated, if there is one.
    task automatic pick_live(output bit found, output logic [gsa_pkg::IDX_W-1:0] slot);
        int start;
        found = 1'b0;
        slot  = '0;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            if (!found && !free_view[(start + k) % SLOTS]) begin
                found = 1'b1;
                slot  = gsa_pkg::IDX_W'((start + k) % SLOTS);
            end
        end
    endtask

    function automatic int lowest_free();
        int low;
        low = -1;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (free_view[k]) begin
                low = k;
            end
        end
        return low;
    endfunction

    // Allocates until no slot is left, then asks once or twice more so that
    // the pool-full response is seen.
    task automatic fill_pool();
        while (free_view != '0) begin
            send_alloc();
        end
        repeat ($urandom_range(1, 2)) send_alloc();
    endtask

    initial begin
        bit                        found;
        logic [gsa_pkg::IDX_W-1:0] slot;
        int                        seq_kind;
        int                        low;
        int                        total;

        i_rst_n                  = 1'b0;
        req_if.valid             = 1'b0;
        req_if.kind              = gsa_pkg::K_ALLOC;
        req_if.handle_valid      = 1'b0;
        req_if.slot_index        = '0;
        req_if.handle_generation = '0;
        rsp_if.ready             = 1'b0;
        idle_en                  = 1'b1;
        stall_left               = 0;
        idle_cycles              = 0;
        words_sent               = 0;
        kind_count               = '{default: 0};

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. The first word waits out the clearing pass.
        // Invalid handles on both handle operations, at the field extremes.
        send_word(gsa_pkg::K_LOOKUP, 1'b0, 6'd63, 8'd255);
        send_word(gsa_pkg::K_FREE,   1'b0, 6'd0,  8'd0);
        // Look up on a slot that is free but whose generation matches.
        send_word(gsa_pkg::K_LOOKUP, 1'b1, 6'd0,  8'd0);
        // Stale handles on look up and free.
        send_word(gsa_pkg::K_LOOKUP, 1'b1, 6'd63, 8'd255);
        send_word(gsa_pkg::K_FREE,   1'b1, 6'd5,  8'd1);
        // Two allocations take slots 0 and 1; the handle fields are all ones.
        send_word(gsa_pkg::K_ALLOC,  1'b1, 6'd63, 8'd255);
        send_word(gsa_pkg::K_ALLOC,  1'b1, 6'd63, 8'd255);
        send_word(gsa_pkg::K_LOOKUP, 1'b1, 6'd0,  8'd0);
        // Free slot 0, then reuse the now stale handle, then free the slot
        // again with its current generation although it is already free.
        send_word(gsa_pkg::K_FREE,   1'b1, 6'd0,  8'd0);
        send_word(gsa_pkg::K_FREE,   1'b1, 6'd0,  8'd0);
        send_word(gsa_pkg::K_FREE,   1'b1, 6'd0,  8'd1);
        send_word(gsa_pkg::K_ALLOC,  1'b0, 6'd0,  8'd0);
        // Reset all makes every handle stale and frees every slot.
        send_word(gsa_pkg::K_RESET,  1'b1, 6'd63, 8'd255);
        send_word(gsa_pkg::K_LOOKUP, 1'b1, 6'd1,  8'd0);
        send_word(gsa_pkg::K_LOOKUP, 1'b1, 6'd63, 8'd1);
        send_word(gsa_pkg::K_FREE,   1'b1, 6'd63, 8'd1);
        send_word(gsa_pkg::K_ALLOC,  1'b0, 6'd0,  8'd0);

        // Random part. It opens with one guaranteed fill of the pool, then
        // runs a mix of short sequences. Many of them use handles taken from
        // the predicted pool so that frees and look ups actually match.
        total = words_sent + RANDOM_WORDS;
        fill_pool();
        while (words_sent < total) begin
            // A quiet stretch in the middle, and none at all near the end.
            idle_en = !((words_sent >= 600 && words_sent < 850) ||
                        (words_sent >= total - 250));
            seq_kind = $urandom_range(0, 99);
            if (seq_kind < 35) begin
                repeat ($urandom_range(1, 6)) send_alloc();
            end else if (seq_kind < 60) begin
                // Frees of live handles; with nothing allocated, a matching
                // free of a slot that is already free.
                repeat ($urandom_range(1, 6)) begin
                    pick_live(found, slot);
                    if (!found) begin
                        slot = gsa_pkg::IDX_W'($urandom_range(0, SLOTS - 1));
                    end
                    send_word(gsa_pkg::K_FREE, 1'b1, slot, gen_view[slot]);
                end
            end else if (seq_kind < 70) begin
                // Look ups of live handles, and stale look ups and frees.
                repeat ($urandom_range(1, 4)) begin
                    pick_live(found, slot);
                    if (!found) begin
                        slot = gsa_pkg::IDX_W'($urandom_range(0, SLOTS - 1));
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        send_word(gsa_pkg::K_LOOKUP, 1'b1, slot, gen_view[slot]);
                    end else begin
                        send_word($urandom_range(0, 1) ? gsa_pkg::K_LOOKUP : gsa_pkg::K_FREE,
                                  1'b1, slot,
                                  gen_view[slot] + gsa_pkg::GEN_W'($urandom_range(1, 255)));
                    end
                end
            end else if (seq_kind < 76) begin
                // Churn on the lowest free slot drives its generation round
                // and round, through the wrap from 255 to 0.
                repeat ($urandom_range(4, 16)) begin
                    low = lowest_free();
                    send_alloc();
                    if (low >= 0) begin
                        send_word(gsa_pkg::K_FREE, 1'b1, gsa_pkg::IDX_W'(low), gen_view[low]);
                    end
                end
            end else if (seq_kind < 78) begin
                fill_pool();
            end else if (seq_kind < 81) begin
                repeat ($urandom_range(1, 3)) begin
                    send_word(gsa_pkg::K_RESET, 1'($urandom_range(0, 1)),
                              gsa_pkg::IDX_W'($urandom_range(0, 63)),
                              gsa_pkg::GEN_W'($urandom_range(0, 255)));
                end
            end else begin
                // Noise: every field random, mostly invalid or stale handles.
                repeat ($urandom_range(1, 4)) begin
                    send_word(gsa_pkg::KIND_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              gsa_pkg::IDX_W'($urandom_range(0, 63)),
                              gsa_pkg::GEN_W'($urandom_range(0, 255)));
                end
            end
        end
        req_if.valid <= 1'b0;

        // Wait for every outstanding response, then watch a few more cycles
        // for any response that should not be there.
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d request words: %0d allocate, %0d free, %0d look up, %0d reset all",
                 words_sent, kind_count[gsa_pkg::K_ALLOC], kind_count[gsa_pkg::K_FREE],
                 kind_count[gsa_pkg::K_LOOKUP], kind_count[gsa_pkg::K_RESET]);
        $display("compared %0d response words, %0d of them with the pool full",
                 checked_count, full_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
